// File: hw/rtl/ipv4_header_generator_top_macros.svh
// ----------------------------------------------------------------------------
// ipv4 header generator assertion macros
// shared concurrent assertion forms, clocked on clk, one form disabled by rst_n
// ----------------------------------------------------------------------------
`ifndef IPV4_HEADER_GENERATOR_TOP_MACROS_SVH
`define IPV4_HEADER_GENERATOR_TOP_MACROS_SVH

// checked only while out of reset
`define IPV4HG_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// checked on every edge, reset included
`define IPV4HG_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: hw/rtl/ipv4hg_pkg.sv
// ----------------------------------------------------------------------------
// ipv4 header generator package
// types and fixed constants shared by the header generator files
// ----------------------------------------------------------------------------
package ipv4hg_pkg;

  localparam int HDR_WORDS   = 10;
  localparam int IDX_W       = 4;
  localparam int SUM_W       = 20;
  localparam int TOTAL_W     = 17;

  localparam logic [15:0] VER_IHL_WORD = 16'h4500;
  localparam logic [7:0]  TTL_VALUE    = 8'd64;
  localparam logic [15:0] HDR_BYTES    = 16'd20;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(HDR_WORDS - 1);

  typedef logic [15:0] word_t;
  typedef logic [31:0] addr_t;

  // configuration register indexes
  typedef enum logic [1:0] {
    CFG_OWN_ADDRESS     = 2'd0,
    CFG_SUBNET_MASK     = 2'd1,
    CFG_GATEWAY_ADDRESS = 2'd2
  } cfg_reg_e;

  typedef struct packed {
    addr_t own_address;
    addr_t subnet_mask;
    addr_t gateway_address;
  } cfg_t;

  typedef struct packed {
    addr_t       dest_address;
    logic [7:0]  proto_number;
    word_t       payload_length;
  } req_t;

  // finished header, word 0 first
  typedef struct packed {
    logic [HDR_WORDS-1:0][15:0] words;
    addr_t                      route_addr;
    logic                       too_large;
  } hdr_t;

endpackage

// File: hw/rtl/ipv4hg_if.sv
// ----------------------------------------------------------------------------
// ipv4 header generator channels
// request, result and configuration write channels, valid/ready
// ----------------------------------------------------------------------------
interface ipv4hg_req_if;
  logic        valid;
  logic        ready;
  logic [31:0] dest_address;
  logic [7:0]  proto_number;
  logic [15:0] payload_length;

  modport source (output valid, dest_address, proto_number, payload_length, input ready);
  modport sink   (input valid, dest_address, proto_number, payload_length, output ready);
endinterface

interface ipv4hg_res_if;
  logic        valid;
  logic        ready;
  logic [15:0] header_word;
  logic [3:0]  word_index;
  logic [31:0] route_addr;
  logic        too_large;
  logic        last_word;

  modport source (output valid, header_word, word_index, route_addr, too_large, last_word,
                  input ready);
  modport sink   (input valid, header_word, word_index, route_addr, too_large, last_word,
                  output ready);
endinterface

interface ipv4hg_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [31:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// File: hw/rtl/ipv4hg_build.sv
// ----------------------------------------------------------------------------
// ipv4 header builder
// size check, next hop choice, header words and one's-complement checksum
// ----------------------------------------------------------------------------
module ipv4hg_build #(
  parameter int MAX_PACKET_BYTES = 1518
) (
  input  ipv4hg_pkg::req_t  req,
  input  ipv4hg_pkg::cfg_t  cfg,
  input  ipv4hg_pkg::word_t ident,
  output ipv4hg_pkg::hdr_t  hdr
);
  import ipv4hg_pkg::*;

  logic [TOTAL_W-1:0]         total;
  logic [HDR_WORDS-1:0][15:0] w;
  logic [SUM_W-1:0]           sum;
  logic [16:0]                fold1;
  logic [16:0]                fold2;
  logic                       on_subnet;

  // total length, compared at full width
  assign total = TOTAL_W'(req.payload_length) + TOTAL_W'(HDR_BYTES);

  assign on_subnet = (req.dest_address & cfg.subnet_mask) ==
                     (cfg.own_address & cfg.subnet_mask);

  // header words with the checksum slot zero
  always_comb begin
    w[0] = VER_IHL_WORD;
    w[1] = total[15:0];
    w[2] = ident;
    w[3] = '0;
    w[4] = {TTL_VALUE, req.proto_number};
    w[5] = '0;
    w[6] = cfg.own_address[31:16];
    w[7] = cfg.own_address[15:0];
    w[8] = req.dest_address[31:16];
    w[9] = req.dest_address[15:0];
  end

  // one's-complement sum with two end-around folds
  always_comb begin
    sum = '0;
    for (int i = 0; i < HDR_WORDS; i++) begin
      sum = sum + SUM_W'(w[i]);
    end
  end

  assign fold1 = 17'(sum[15:0]) + 17'(sum[SUM_W-1:16]);
  assign fold2 = 17'(fold1[15:0]) + 17'(fold1[16]);

  always_comb begin
    hdr.words      = w;
    hdr.words[5]   = ~fold2[15:0];
    hdr.route_addr = on_subnet ? req.dest_address : cfg.gateway_address;
    hdr.too_large  = total > TOTAL_W'(MAX_PACKET_BYTES);
    // error result carries zero payload
    if (hdr.too_large) begin
      hdr.words      = '0;
      hdr.route_addr = '0;
    end
  end

endmodule

// File: hw/rtl/ipv4hg_serializer.sv
// ----------------------------------------------------------------------------
// ipv4 header serializer
// holds one built header and sends it one word per transfer
// ----------------------------------------------------------------------------
module ipv4hg_serializer (
  input  logic                  clk,
  input  logic                  rst_n,
  input  ipv4hg_pkg::hdr_t      hdr,
  input  logic                  load,
  output logic                  can_load,
  ipv4hg_res_if.source          res
);
  import ipv4hg_pkg::*;

  logic                       valid_r, valid_nxt;
  logic [IDX_W-1:0]           idx_r, idx_nxt;
  logic [HDR_WORDS-1:0][15:0] words_r, words_nxt;
  addr_t                      hop_r, hop_nxt;
  logic                       err_r, err_nxt;
  logic                       xfer;
  logic                       last;

  assign last     = err_r || (idx_r == LAST_IDX);
  assign xfer     = valid_r && res.ready;
  assign can_load = !valid_r || (xfer && last);

  // word shift and index count
  always_comb begin
    valid_nxt = valid_r;
    idx_nxt   = idx_r;
    words_nxt = words_r;
    hop_nxt   = hop_r;
    err_nxt   = err_r;
    if (xfer) begin
      valid_nxt = !last;
      idx_nxt   = idx_r + IDX_W'(1);
      words_nxt = {16'h0000, words_r[HDR_WORDS-1:1]};
    end
    if (load) begin
      valid_nxt = 1'b1;
      idx_nxt   = '0;
      words_nxt = hdr.words;
      hop_nxt   = hdr.route_addr;
      err_nxt   = hdr.too_large;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      idx_r   <= '0;
      err_r   <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
      idx_r   <= idx_nxt;
      err_r   <= err_nxt;
    end
  end

  always_ff @(posedge clk) begin
    words_r <= words_nxt;
    hop_r   <= hop_nxt;
  end

  // result channel straight from registers
  assign res.valid       = valid_r;
  assign res.header_word = words_r[0];
  assign res.word_index  = idx_r;
  assign res.route_addr  = hop_r;
  assign res.too_large   = err_r;
  assign res.last_word   = last;

endmodule

// File: hw/rtl/ipv4_header_generator_top.sv
// Path: a request transfer is captured in the request register, then loaded
// into the serializer registers, which drive the result channel directly.
// Throughput: a fitting request sends 10 words, one per cycle while the receiver
// is ready; an oversized request sends a single error word, one per cycle while ready.
// The word serializer sets the rate; the request register takes the next
// request while the current header is still going out.
// Reset: rst_n synchronous, active low; clears config, ident counter, valids.
// ----------------------------------------------------------------------------
// ipv4 header generator top
// builds 20-byte ipv4 headers with checksum and next hop, word per transfer
// ----------------------------------------------------------------------------
`include "ipv4_header_generator_top_macros.svh"

module ipv4_header_generator_top #(
  parameter int MAX_PACKET_BYTES = 1518
) (
  input  logic          clk,
  input  logic          rst_n,
  ipv4hg_req_if.sink    in_req,
  ipv4hg_res_if.source  out_res,
  ipv4hg_cfg_if.sink    cfg_wr
);
  import ipv4hg_pkg::*;

  cfg_t      cfg_r, cfg_nxt;
  logic      req_valid_r, req_valid_nxt;
  req_t      req_r, req_nxt;
  word_t     ident_r, ident_nxt;
  hdr_t      hdr;
  logic      ser_load;
  logic      ser_can_load;
  logic      in_xfer;

  // configuration writes, always ready
  assign cfg_wr.ready = 1'b1;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_wr.valid) begin
      case (cfg_reg_e'(cfg_wr.index))
        CFG_OWN_ADDRESS:     cfg_nxt.own_address     = cfg_wr.data;
        CFG_SUBNET_MASK:     cfg_nxt.subnet_mask     = cfg_wr.data;
        CFG_GATEWAY_ADDRESS: cfg_nxt.gateway_address = cfg_wr.data;
        default:             cfg_nxt = cfg_r;
      endcase
    end
  end

  // request register, free when empty or handing off this cycle
  assign ser_load     = req_valid_r && ser_can_load;
  assign in_req.ready = !req_valid_r || ser_load;
  assign in_xfer      = in_req.valid && in_req.ready;

  always_comb begin
    req_valid_nxt = req_valid_r;
    req_nxt       = req_r;
    if (ser_load) begin
      req_valid_nxt = 1'b0;
    end
    if (in_xfer) begin
      req_valid_nxt          = 1'b1;
      req_nxt.dest_address   = in_req.dest_address;
      req_nxt.proto_number   = in_req.proto_number;
      req_nxt.payload_length = in_req.payload_length;
    end
  end

  // identification advances once per emitted header, not for oversized requests
  assign ident_nxt = (ser_load && !hdr.too_large) ? ident_r + 16'd1 : ident_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r       <= '0;
      req_valid_r <= 1'b0;
      ident_r     <= '0;
    end else begin
      cfg_r       <= cfg_nxt;
      req_valid_r <= req_valid_nxt;
      ident_r     <= ident_nxt;
    end
  end

  always_ff @(posedge clk) begin
    req_r <= req_nxt;
  end

  ipv4hg_build #(
    .MAX_PACKET_BYTES(MAX_PACKET_BYTES)
  ) u_build (
    .req   (req_r),
    .cfg   (cfg_r),
    .ident (ident_r),
    .hdr   (hdr)
  );

  ipv4hg_serializer u_ser (
    .clk      (clk),
    .rst_n    (rst_n),
    .hdr      (hdr),
    .load     (ser_load),
    .can_load (ser_can_load),
    .res      (out_res)
  );

  // checks
  `IPV4HG_ASSERT(a_idx_range, out_res.valid |-> out_res.word_index <= LAST_IDX, "word index past last header word")
  `IPV4HG_ASSERT(a_err_single, (out_res.valid && out_res.too_large) |-> (out_res.last_word && out_res.word_index == '0), "error result not a single last word")
  `IPV4HG_ASSERT(a_hdr_continues, (out_res.valid && out_res.ready && !out_res.last_word) |=> (out_res.valid && out_res.word_index == $past(out_res.word_index) + IDX_W'(1)), "header stream broke before last word")
  `IPV4HG_ASSERT(a_ident_step, (ident_r != $past(ident_r)) |-> $past(ser_load && !hdr.too_large), "ident counter moved without a header")
  `IPV4HG_ASSERT_ALWAYS(a_reset_idle, !rst_n |=> (!out_res.valid && in_req.ready), "block not idle after reset")

endmodule

// File: verif/ipv4hg_header_checker.sv
// ----------------------------------------------------------------------------
// ipv4 header generator checker
// watches the config, request and result channels, predicts each header
// word with its own copy of the registers and ident counter, and compares
// every result transfer against the oldest predicted word
// ----------------------------------------------------------------------------
module ipv4hg_header_checker #(
  parameter int MAX_PACKET_BYTES = 1518
) (
  input  logic   clk,
  input  logic   rst_n,
  ipv4hg_req_if  in_req,
  ipv4hg_res_if  out_res,
  ipv4hg_cfg_if  cfg_wr,
  input  logic   end_check,
  output int     pending_words,
  output int     fail_count,
  output int     words_checked,
  output int     oversize_checked
);
  import ipv4hg_pkg::*;

  typedef struct packed {
    word_t            header_word;
    logic [IDX_W-1:0] word_index;
    addr_t            route_addr;
    logic             too_large;
    logic             last_word;
  } hdr_word_t;

  localparam int MAX_PRINTED = 30;

  hdr_word_t expected_words[$];
  addr_t     own_addr;
  addr_t     net_mask;
  addr_t     gw_addr;
  word_t     ident_count;
  int        mismatch_count;

  assign fail_count = mismatch_count;

  task automatic report_mismatch(input string msg);
    mismatch_count++;
    if (mismatch_count <= MAX_PRINTED) $display("checker: mismatch: %s", msg);
  endtask

  // build the ten header words (or the single oversize word) for one request
  function automatic void predict_header(input addr_t dest, input logic [7:0] proto,
                                         input word_t plen);
    logic [16:0] total;
    logic [31:0] acc;
    word_t       w [HDR_WORDS];
    addr_t       hop;
    hdr_word_t   e;
    total = 17'd20 + 17'(plen);
    if (total > 17'(MAX_PACKET_BYTES)) begin
      e = '0;
      e.too_large = 1'b1;
      e.last_word = 1'b1;
      expected_words.push_back(e);
      return;
    end
    hop = ((dest & net_mask) == (own_addr & net_mask)) ? dest : gw_addr;
    w[0] = 16'h4500;
    w[1] = total[15:0];
    w[2] = ident_count;
    w[3] = 16'h0000;
    w[4] = {8'd64, proto};
    w[5] = 16'h0000;
    w[6] = own_addr[31:16];
    w[7] = own_addr[15:0];
    w[8] = dest[31:16];
    w[9] = dest[15:0];
    // one's-complement sum with end-around carry, folded twice
    acc = '0;
    for (int k = 0; k < HDR_WORDS; k++) acc += 32'(w[k]);
    acc = (acc >> 16) + (acc & 32'h0000_FFFF);
    acc = acc + (acc >> 16);
    w[5] = ~acc[15:0];
    ident_count = ident_count + 16'd1;
    for (int k = 0; k < HDR_WORDS; k++) begin
      e.header_word = w[k];
      e.word_index  = IDX_W'(k);
      e.route_addr  = hop;
      e.too_large   = 1'b0;
      e.last_word   = (k == HDR_WORDS - 1);
      expected_words.push_back(e);
    end
  endfunction

  // compare one result transfer field by field
  task automatic check_word();
    hdr_word_t want;
    if (expected_words.size() == 0) begin
      report_mismatch($sformatf("unexpected result word %h index %0d too_large %0b",
                                out_res.header_word, out_res.word_index,
                                out_res.too_large));
      return;
    end
    want = expected_words.pop_front();
    if (want.too_large) oversize_checked++;
    else words_checked++;
    if (out_res.header_word !== want.header_word)
      report_mismatch($sformatf("header_word %h, expected %h (index %0d)",
                                out_res.header_word, want.header_word, want.word_index));
    if (out_res.word_index !== want.word_index)
      report_mismatch($sformatf("word_index %0d, expected %0d",
                                out_res.word_index, want.word_index));
    if (out_res.route_addr !== want.route_addr)
      report_mismatch($sformatf("route_addr %h, expected %h (index %0d)",
                                out_res.route_addr, want.route_addr, want.word_index));
    if (out_res.too_large !== want.too_large)
      report_mismatch($sformatf("too_large %0b, expected %0b",
                                out_res.too_large, want.too_large));
    if (out_res.last_word !== want.last_word)
      report_mismatch($sformatf("last_word %0b, expected %0b (index %0d)",
                                out_res.last_word, want.last_word, want.word_index));
  endtask

  // config shadow, prediction on request transfer, compare on result transfer
  always @(posedge clk) begin
    if (!rst_n) begin
      expected_words.delete();
      own_addr         = '0;
      net_mask         = '0;
      gw_addr          = '0;
      ident_count      = '0;
      mismatch_count   = 0;
      words_checked    = 0;
      oversize_checked = 0;
    end else begin
      if (cfg_wr.valid && cfg_wr.ready) begin
        case (cfg_wr.index)
          CFG_OWN_ADDRESS:     own_addr = cfg_wr.data;
          CFG_SUBNET_MASK:     net_mask = cfg_wr.data;
          CFG_GATEWAY_ADDRESS: gw_addr  = cfg_wr.data;
          default: ;
        endcase
      end
      if (in_req.valid && in_req.ready)
        predict_header(in_req.dest_address, in_req.proto_number, in_req.payload_length);
      if (out_res.valid && out_res.ready) check_word();
      if (end_check && expected_words.size() != 0) begin
        report_mismatch($sformatf("%0d expected words never arrived",
                                  expected_words.size()));
        expected_words.delete();
      end
    end
    pending_words <= expected_words.size();
  end

endmodule

// File: verif/tb_ipv4_header_generator_top.sv
// ----------------------------------------------------------------------------
// ipv4 header generator testbench
// directed requests cover subnet and gateway routing, size limit edges and
// wraparound lengths; random requests follow under several register settings
// with bursty requests and a stalling receiver; the checker compares results
// ----------------------------------------------------------------------------
module tb_ipv4_header_generator_top;
  import ipv4hg_pkg::*;

  localparam int          MAX_PACKET_BYTES = 1518;
  localparam int          CYCLE_LIMIT      = 200000;
  localparam int          RANDOM_PHASES    = 5;
  localparam int          PHASE_REQUESTS   = 30;
  localparam int          DRAIN_CYCLES     = 4;
  localparam logic [1:0]  CFG_UNUSED_INDEX = 2'd3;

  logic clk;
  logic rst_n;
  logic end_check;
  int   pending_words;
  int   fail_count;
  int   words_checked;
  int   oversize_checked;
  int   cycle_count = 0;
  int   burst_left;
  int   requests_sent;
  int   settings_used;
  int   stall_left;
  int   stall_mode;

  ipv4hg_req_if in_req ();
  ipv4hg_res_if out_res ();
  ipv4hg_cfg_if cfg_wr ();

  ipv4_header_generator_top #(
    .MAX_PACKET_BYTES(MAX_PACKET_BYTES)
  ) dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_req  (in_req),
    .out_res (out_res),
    .cfg_wr  (cfg_wr)
  );

  ipv4hg_header_checker #(
    .MAX_PACKET_BYTES(MAX_PACKET_BYTES)
  ) u_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_req           (in_req),
    .out_res          (out_res),
    .cfg_wr           (cfg_wr),
    .end_check        (end_check),
    .pending_words    (pending_words),
    .fail_count       (fail_count),
    .words_checked    (words_checked),
    .oversize_checked (oversize_checked)
  );

  // clock
  always #5 clk = ~clk;

  // run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("checker: no progress after %0d cycles", cycle_count);
      $display("tb: failure");
      $finish;
    end
  end

  // receiver stall pattern: modes from always ready to mostly stalled
  always @(posedge clk) begin
    if (!rst_n) begin
      stall_mode    <= 0;
      stall_left    <= 0;
      out_res.ready <= 1'b0;
    end else begin
      if (stall_left == 0) begin
        stall_mode <= $urandom_range(0, 3);
        stall_left <= $urandom_range(8, 40);
      end else begin
        stall_left <= stall_left - 1;
      end
      case (stall_mode)
        0:       out_res.ready <= 1'b1;
        1:       out_res.ready <= 1'($urandom_range(0, 1));
        2:       out_res.ready <= ($urandom_range(0, 3) != 0);
        default: out_res.ready <= ($urandom_range(0, 5) == 0);
      endcase
    end
  end

  // one request transfer, with bursts and random gaps between them
  task automatic send_request(input addr_t dest, input logic [7:0] proto, input word_t plen);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        in_req.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 12);
    end
    in_req.valid          <= 1'b1;
    in_req.dest_address   <= dest;
    in_req.proto_number   <= proto;
    in_req.payload_length <= plen;
    do @(posedge clk); while (!in_req.ready);
    burst_left--;
    requests_sent++;
  endtask

  // hold requests until every predicted word has come out
  task automatic wait_for_drain();
    in_req.valid <= 1'b0;
    do @(posedge clk); while (pending_words != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_register(input logic [1:0] idx, input addr_t value);
    cfg_wr.valid <= 1'b1;
    cfg_wr.index <= idx;
    cfg_wr.data  <= value;
    do @(posedge clk); while (!cfg_wr.ready);
  endtask

  // all three registers plus a write to the unused index
  task automatic program_config(input addr_t own, input addr_t mask, input addr_t gw);
    write_register(CFG_OWN_ADDRESS, own);
    write_register(CFG_SUBNET_MASK, mask);
    write_register(CFG_UNUSED_INDEX, $urandom);
    write_register(CFG_GATEWAY_ADDRESS, gw);
    cfg_wr.valid <= 1'b0;
    settings_used++;
  endtask

  initial begin
    addr_t own;
    addr_t mask;
    addr_t gw;
    addr_t dest;
    word_t plen;
    int    kind;

    clk                   = 1'b0;
    rst_n                 = 1'b0;
    end_check             = 1'b0;
    burst_left            = 0;
    requests_sent         = 0;
    settings_used         = 1;
    in_req.valid          = 1'b0;
    in_req.dest_address   = '0;
    in_req.proto_number   = '0;
    in_req.payload_length = '0;
    cfg_wr.valid          = 1'b0;
    cfg_wr.index          = CFG_OWN_ADDRESS;
    cfg_wr.data           = '0;

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset register values: zero mask makes every destination local
    send_request(32'h0A00_0001, 8'd6, 16'd0);
    send_request(32'hFFFF_FFFF, 8'd255, 16'd1498);
    send_request(32'h0000_0000, 8'd0, 16'd1499);

    // typical /24 setup: local and remote hops, size limit edges
    wait_for_drain();
    program_config(32'hC0A8_010A, 32'hFFFF_FF00, 32'hC0A8_0101);
    send_request(32'hC0A8_0164, 8'd17, 16'd100);
    send_request(32'h0808_0808, 8'd6, 16'd1000);
    send_request(32'hC0A8_01FF, 8'd0, 16'd0);
    send_request(32'h0000_0000, 8'd255, 16'd1498);
    send_request(32'hFFFF_FFFF, 8'd255, 16'd1498);
    send_request(32'hC0A8_0102, 8'd1, 16'd1499);
    // lengths that would fit if the sum wrapped at 16 bits
    send_request(32'hC0A8_0103, 8'd1, 16'd65535);
    send_request(32'hC0A8_0104, 8'd1, 16'd65516);
    send_request(32'h0A0B_0C0D, 8'hAA, 16'h5555);
    send_request(32'h5555_5555, 8'h55, 16'hAAAA);
    send_request(32'hAAAA_AAAA, 8'hAA, 16'h0555);

    // all-ones own address and mask: only an exact match is local
    wait_for_drain();
    program_config(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0000_0000);
    send_request(32'hFFFF_FFFF, 8'd6, 16'd1498);
    send_request(32'hFFFF_FFFE, 8'd6, 16'd20);
    send_request(32'h7FFF_FFFF, 8'd17, 16'd0);

    // random phases, each under its own register setting
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      wait_for_drain();
      own  = $urandom;
      gw   = $urandom;
      case (p)
        0:       mask = '0;
        1:       begin
          mask = '1;
          gw   = '1;
        end
        default: mask = 32'hFFFF_FFFF << (32 - $urandom_range(1, 31));
      endcase
      program_config(own, mask, gw);
      for (int k = 0; k < PHASE_REQUESTS; k++) begin
        // let the pipeline empty once mid-phase
        if (p == 2 && k == PHASE_REQUESTS / 2) wait_for_drain();
        dest = $urandom;
        if ($urandom_range(0, 1) == 1) dest = (own & mask) | (dest & ~mask);
        kind = $urandom_range(0, 9);
        if (kind == 0)
          plen = word_t'($urandom_range(MAX_PACKET_BYTES - 19, 65535));
        else if (kind == 1)
          plen = ($urandom_range(0, 1) == 1) ? word_t'(MAX_PACKET_BYTES - 20) : 16'd0;
        else
          plen = word_t'($urandom_range(0, MAX_PACKET_BYTES - 20));
        send_request(dest, 8'($urandom_range(0, 255)), plen);
      end
    end

    // drain, then flag anything still outstanding
    wait_for_drain();
    end_check <= 1'b1;
    repeat (2) @(posedge clk);

    $display("run covered %0d requests under %0d register settings:", requests_sent,
             settings_used);
    $display("  %0d header words and %0d oversize results compared, %0d mismatches",
             words_checked, oversize_checked, fail_count);
    if (fail_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

// File: files.f
+incdir+hw/rtl
hw/rtl/ipv4hg_pkg.sv
hw/rtl/ipv4hg_if.sv
hw/rtl/ipv4hg_build.sv
hw/rtl/ipv4hg_serializer.sv
hw/rtl/ipv4_header_generator_top.sv
verif/ipv4hg_header_checker.sv
verif/tb_ipv4_header_generator_top.sv
